/* design/tea_pkg.sv */
package tea_pkg;

	localparam int          ROUNDS_DEFAULT = 32;
	localparam logic [31:0] TEA_DELTA      = 32'h9E37_79B9;
	localparam int          WORD_W         = 32;
	localparam int          KEY_WORDS      = 4;
	localparam int          CFG_INDEX_W    = 3;

	typedef enum logic [CFG_INDEX_W-1:0] {
		KEY_WORD0 = 3'd0,
		KEY_WORD1 = 3'd1,
		KEY_WORD2 = 3'd2,
		KEY_WORD3 = 3'd3
	} cfg_reg_t;

	typedef logic [KEY_WORDS-1:0][WORD_W-1:0] key_t;

	typedef struct packed {
		logic              mode;
		logic [WORD_W-1:0] block_left;
		logic [WORD_W-1:0] block_right;
	} in_t;

	typedef struct packed {
		logic [WORD_W-1:0] result_left;
		logic [WORD_W-1:0] result_right;
	} out_t;

	typedef struct packed {
		logic              valid;
		logic              mode;
		logic [WORD_W-1:0] left;
		logic [WORD_W-1:0] right;
	} stage_t;

endpackage

/* design/tea_block_cipher.sv */
// TEA block cipher engine, 64-bit block, 128-bit key.
// Input beat: start with data_in (mode, block_left, block_right). A beat is
// taken at every rising edge where start is high and busy is low; busy stays
// low, so one block can be given in every cycle, encrypt and decrypt mixed.
// Result beat: done is high for one cycle with result (result_left,
// result_right). The receiver cannot hold results off and none is needed.
// Throughput: one block per cycle, set by a chain of 2*ROUNDS cells, each
// doing one half-round and registering it; done and result come from the
// register of the last cell.
// Key: four words written over cfg_we, cfg_index and cfg_data, one word per
// edge; indexes past the last key word are ignored. Write the key only while
// no block is in the chain.
// Reset clears the key to zero and drops every block in flight; no result
// beat appears until new blocks are given.
module tea_block_cipher #(
	parameter int ROUNDS = tea_pkg::ROUNDS_DEFAULT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  tea_pkg::in_t                    data_in,
	output logic                            done,
	output tea_pkg::out_t                   result,
	input  logic                            cfg_we,
	input  logic [tea_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [tea_pkg::WORD_W-1:0]      cfg_data
);
	import tea_pkg::*;

	localparam int STEPS = 2 * ROUNDS;

	key_t   key_q;
	stage_t stage [0:STEPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				KEY_WORD0: key_q[0] <= cfg_data;
				KEY_WORD1: key_q[1] <= cfg_data;
				KEY_WORD2: key_q[2] <= cfg_data;
				KEY_WORD3: key_q[3] <= cfg_data;
				default:   key_q    <= key_q;
			endcase
		end
	end

	assign busy = 1'b0;

	always_comb begin
		stage[0].valid = start && !busy;
		stage[0].mode  = data_in.mode;
		stage[0].left  = data_in.block_left;
		stage[0].right = data_in.block_right;
	end

	for (genvar g = 0; g < STEPS; g++) begin : g_cell
		tea_round_cell #(
			.ROUNDS (ROUNDS),
			.STEP   (g)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.key       (key_q),
			.stage_in  (stage[g]),
			.stage_out (stage[g+1])
		);
	end

	assign done                = stage[STEPS].valid;
	assign result.result_left  = stage[STEPS].left;
	assign result.result_right = stage[STEPS].right;

endmodule

/* design/tea_round_cell.sv */
module tea_round_cell #(
	parameter int ROUNDS = tea_pkg::ROUNDS_DEFAULT,
	parameter int STEP   = 0
) (
	input  logic           clk,
	input  logic           arst_n,
	input  tea_pkg::key_t   key,
	input  tea_pkg::stage_t stage_in,
	output tea_pkg::stage_t stage_out
);
	import tea_pkg::*;

	localparam int          ROUND   = STEP / 2;
	localparam bit          FIRST   = (STEP % 2) == 0;
	localparam logic [31:0] SUM_ENC = 32'(TEA_DELTA * 32'(ROUND + 1));
	localparam logic [31:0] SUM_DEC = 32'(TEA_DELTA * 32'(ROUNDS - ROUND));

	logic              to_left;
	logic [WORD_W-1:0] src;
	logic [WORD_W-1:0] dst;
	logic [WORD_W-1:0] ka;
	logic [WORD_W-1:0] kb;
	logic [WORD_W-1:0] sum;
	logic [WORD_W-1:0] mix;
	logic [WORD_W-1:0] upd;
	logic              valid_q;
	logic              mode_q;
	logic [WORD_W-1:0] left_q;
	logic [WORD_W-1:0] right_q;

	// Each cell is one half of a round. Encryption updates the left half first,
	// decryption undoes the right half first.
	always_comb begin
		to_left = FIRST ^ stage_in.mode;
		src     = to_left ? stage_in.right : stage_in.left;
		dst     = to_left ? stage_in.left : stage_in.right;
		ka      = to_left ? key[0] : key[2];
		kb      = to_left ? key[1] : key[3];
		sum     = stage_in.mode ? SUM_DEC : SUM_ENC;
		mix     = ((src << 4) + ka) ^ (src + sum) ^ ((src >> 5) + kb);
		upd     = stage_in.mode ? (dst - mix) : (dst + mix);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= stage_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		mode_q  <= stage_in.mode;
		left_q  <= to_left ? upd : stage_in.left;
		right_q <= to_left ? stage_in.right : upd;
	end

	assign stage_out = {valid_q, mode_q, left_q, right_q};

endmodule

/* design/tea_checker.sv */
module tea_checker #(
	parameter int ROUNDS = tea_pkg::ROUNDS_DEFAULT
) (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            start,
	input logic                            busy,
	input tea_pkg::in_t                    data_in,
	input logic                            done,
	input tea_pkg::out_t                   result,
	input logic                            cfg_we,
	input logic [tea_pkg::CFG_INDEX_W-1:0] cfg_index,
	input logic [tea_pkg::WORD_W-1:0]      cfg_data
);
	import tea_pkg::*;

	localparam int STEPS = 2 * ROUNDS;

	a_always_ready: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy went high");

	a_done_has_beat: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, STEPS))
		else $error("result beat without a matching input beat");

	a_reset_quiet: assert property (@(posedge clk) !arst_n |-> !done)
		else $error("result beat during reset");

	a_first_after_reset: assert property (@(posedge clk) $rose(arst_n) |-> !done)
		else $error("result beat right after reset");

endmodule

bind tea_block_cipher tea_checker #(.ROUNDS(ROUNDS)) u_tea_checker (.*);

/* bench/tea_block_cipher_tb.sv */
`timescale 1ns / 100ps

module tea_block_cipher_tb;

	import tea_pkg::*;

	localparam int          ROUND_COUNT  = ROUNDS_DEFAULT;
	localparam logic        MODE_ENCRYPT = 1'b0;
	localparam logic        MODE_DECRYPT = 1'b1;
	localparam int          MAX_GAP      = 17;
	localparam int          STALL_LIMIT  = 1000;
	localparam int          TAIL_CYCLES  = 2 * ROUND_COUNT + 8;
	localparam int          REPORT_MAX   = 10;
	localparam int          KEY_PHASES   = 8;
	localparam int          PHASE_BLOCKS = 229;

	typedef enum logic [1:0] {
		JOB_BLOCK,
		JOB_KEY,
		JOB_DRAIN
	} job_kind_t;

	typedef struct {
		job_kind_t              kind;
		in_t                    blk;
		logic [CFG_INDEX_W-1:0] reg_index;
		logic [WORD_W-1:0]      reg_value;
		int unsigned            gap;
	} job_t;

	logic                   clk       = 1'b0;
	logic                   arst_n;
	logic                   start     = 1'b0;
	logic                   busy;
	in_t                    data_in   = '0;
	logic                   done;
	out_t                   result;
	logic                   cfg_we    = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [WORD_W-1:0]      cfg_data  = '0;

	job_t        jobs[$];
	job_t        cur_job;
	logic        job_open     = 1'b0;
	int unsigned gap_left     = 0;
	logic        no_idle      = 1'b0;
	logic        beat_taken   = 1'b0;
	key_t        key_words    = '0;
	out_t        cipher_due[$];
	int unsigned fail_count   = 0;
	int unsigned result_count = 0;
	int unsigned quiet_cycles = 0;

	tea_block_cipher i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.data_in   (data_in),
		.done      (done),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic logic [WORD_W-1:0] tea_round_mix(input logic [WORD_W-1:0] half,
		input logic [WORD_W-1:0] sum, input logic [WORD_W-1:0] ka,
		input logic [WORD_W-1:0] kb);
		return ((half << 4) + ka) ^ (half + sum) ^ ((half >> 5) + kb);
	endfunction

	function automatic out_t tea_cipher(input in_t blk, input key_t k);
		logic [WORD_W-1:0] l;
		logic [WORD_W-1:0] r;
		logic [WORD_W-1:0] s;
		out_t              res;
		l = blk.block_left;
		r = blk.block_right;
		if (blk.mode == MODE_ENCRYPT) begin
			s = '0;
			for (int n = 0; n < ROUND_COUNT; n++) begin
				s = s + TEA_DELTA;
				l = l + tea_round_mix(r, s, k[0], k[1]);
				r = r + tea_round_mix(l, s, k[2], k[3]);
			end
		end else begin
			s = TEA_DELTA * WORD_W'(ROUND_COUNT);
			for (int n = 0; n < ROUND_COUNT; n++) begin
				r = r - tea_round_mix(l, s, k[2], k[3]);
				l = l - tea_round_mix(r, s, k[0], k[1]);
				s = s - TEA_DELTA;
			end
		end
		res.result_left  = l;
		res.result_right = r;
		return res;
	endfunction

	function automatic logic [WORD_W-1:0] pick_word();
		case ($urandom_range(0, 15))
			0: return '0;
			1: return '1;
			2: return 32'h8000_0000;
			3: return 32'h7FFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	task automatic queue_block(input logic mode, input logic [WORD_W-1:0] l,
		input logic [WORD_W-1:0] r);
		job_t j;
		j.kind              = JOB_BLOCK;
		j.blk.mode          = mode;
		j.blk.block_left    = l;
		j.blk.block_right   = r;
		j.reg_index         = '0;
		j.reg_value         = '0;
		j.gap               = no_idle ? 0 : $urandom_range(0, MAX_GAP);
		jobs.push_back(j);
	endtask

	task automatic queue_key_write(input logic [CFG_INDEX_W-1:0] idx,
		input logic [WORD_W-1:0] val);
		job_t j;
		j.kind      = JOB_KEY;
		j.blk       = '0;
		j.reg_index = idx;
		j.reg_value = val;
		j.gap       = 0;
		jobs.push_back(j);
	endtask

	task automatic queue_drain();
		job_t j;
		j.kind      = JOB_DRAIN;
		j.blk       = '0;
		j.reg_index = '0;
		j.reg_value = '0;
		j.gap       = 0;
		jobs.push_back(j);
	endtask

	task automatic report_mismatch(input string what, input logic [WORD_W-1:0] want,
		input logic [WORD_W-1:0] got);
		fail_count++;
		if (fail_count <= REPORT_MAX)
			$display("result %0d: %s expected %h, got %h", result_count, what, want, got);
	endtask

	// Key writes wait until every block in flight has come out, since every
	// block gives exactly one result beat.
	always @(negedge clk) begin
		logic nxt_start;
		logic nxt_we;
		nxt_start = start;
		nxt_we    = 1'b0;
		if (arst_n) begin
			if (start && beat_taken) begin
				nxt_start = 1'b0;
				job_open  = 1'b0;
			end
			if (!job_open && jobs.size() != 0) begin
				cur_job  = jobs.pop_front();
				job_open = 1'b1;
				gap_left = cur_job.gap;
			end
			if (job_open) begin
				case (cur_job.kind)
					JOB_BLOCK: begin
						if (gap_left != 0) begin
							gap_left--;
						end else begin
							nxt_start = 1'b1;
							data_in <= cur_job.blk;
						end
					end
					JOB_KEY: begin
						if (cipher_due.size() == 0) begin
							nxt_we = 1'b1;
							cfg_index <= cur_job.reg_index;
							cfg_data  <= cur_job.reg_value;
							job_open  = 1'b0;
						end
					end
					default: begin
						if (cipher_due.size() == 0)
							job_open = 1'b0;
					end
				endcase
			end
		end
		start  <= nxt_start;
		cfg_we <= nxt_we;
	end

	always @(posedge clk) begin
		out_t want;
		beat_taken = arst_n && start && !busy;
		if (beat_taken)
			cipher_due.push_back(tea_cipher(data_in, key_words));
		if (arst_n && cfg_we && cfg_index < KEY_WORDS)
			key_words[cfg_index[1:0]] = cfg_data;
		if (arst_n && done) begin
			if (cipher_due.size() == 0) begin
				fail_count++;
				if (fail_count <= REPORT_MAX)
					$display("result %0d: unexpected beat %h_%h", result_count,
						result.result_left, result.result_right);
			end else begin
				want = cipher_due.pop_front();
				if (result.result_left !== want.result_left)
					report_mismatch("result_left", want.result_left, result.result_left);
				if (result.result_right !== want.result_right)
					report_mismatch("result_right", want.result_right, result.result_right);
			end
			result_count++;
		end
		if (beat_taken || done || cfg_we)
			quiet_cycles = 0;
		else
			quiet_cycles++;
	end

	initial begin
		logic timed_out;
		timed_out = 1'b0;
		arst_n <= 1'b0;

		queue_block(MODE_ENCRYPT, '0, '0);
		queue_block(MODE_DECRYPT, '0, '0);
		queue_block(MODE_ENCRYPT, '1, '1);
		queue_block(MODE_DECRYPT, '1, '1);
		for (int w = 0; w < KEY_WORDS; w++)
			queue_key_write(cfg_reg_t'(w), '1);
		queue_block(MODE_ENCRYPT, '0, '1);
		queue_block(MODE_DECRYPT, '1, '0);
		queue_block(MODE_ENCRYPT, 32'h8000_0000, 32'h0000_0001);
		queue_block(MODE_DECRYPT, 32'h0000_0001, 32'h8000_0000);
		queue_key_write(KEY_WORD0, 32'h0123_4567);
		queue_key_write(KEY_WORD1, 32'h89AB_CDEF);
		queue_key_write(KEY_WORD2, 32'hFEDC_BA98);
		queue_key_write(KEY_WORD3, 32'h7654_3210);
		queue_block(MODE_ENCRYPT, 32'h0123_4567, 32'h89AB_CDEF);
		queue_block(MODE_DECRYPT, '0, '0);
		// Writes past the last key word must leave the key untouched.
		for (int w = 0; w < KEY_WORDS; w++)
			queue_key_write(CFG_INDEX_W'(KEY_WORDS + w), '1);
		queue_block(MODE_ENCRYPT, 32'h0123_4567, 32'h89AB_CDEF);
		queue_block(MODE_DECRYPT, '0, '0);
		no_idle = 1'b1;
		for (int n = 0; n < 8; n++)
			queue_block(logic'($urandom_range(0, 1)), pick_word(), pick_word());
		no_idle = 1'b0;

		for (int ph = 0; ph < KEY_PHASES; ph++) begin
			for (int w = 0; w < KEY_WORDS; w++) begin
				if (ph == 0)
					queue_key_write(cfg_reg_t'(w), '0);
				else if (ph == 1)
					queue_key_write(cfg_reg_t'(w), '1);
				else
					queue_key_write(cfg_reg_t'(w), pick_word());
				if ($urandom_range(0, 3) == 0)
					queue_key_write(CFG_INDEX_W'($urandom_range(KEY_WORDS,
						(1 << CFG_INDEX_W) - 1)), $urandom);
			end
			for (int n = 0; n < PHASE_BLOCKS; n++) begin
				if ($urandom_range(0, 39) == 0)
					no_idle = !no_idle;
				if (ph == 3 && n == PHASE_BLOCKS / 2)
					queue_drain();
				queue_block(logic'($urandom_range(0, 1)), pick_word(), pick_word());
			end
		end

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (!timed_out && (jobs.size() != 0 || job_open || start ||
			cipher_due.size() != 0)) begin
			@(posedge clk);
			if (quiet_cycles >= STALL_LIMIT)
				timed_out = 1'b1;
		end

		if (timed_out) begin
			$display("Some tests failed");
		end else begin
			repeat (TAIL_CYCLES) @(posedge clk);
			if (fail_count == 0 && cipher_due.size() == 0)
				$display("All tests passed");
			else
				$display("Some tests failed");
		end
		$finish;
	end

endmodule

/* files.f */
design/tea_pkg.sv
design/tea_round_cell.sv
design/tea_block_cipher.sv
design/tea_checker.sv
bench/tea_block_cipher_tb.sv
